FILE: rtl/core/pdq_pkg.sv
package pdq_pkg;

	// default sizes
	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int PALETTE_SIZE_DEF = 64;
	localparam int ERROR_BITS_DEF   = 12;
	localparam int MAX_HEIGHT       = 1024;

	// luma weights, sum is 65536
	localparam logic [15:0] LUMA_KR = 16'd19595;
	localparam logic [15:0] LUMA_KG = 16'd38470;
	localparam logic [15:0] LUMA_KB = 16'd7471;

	// cube levels
	localparam logic [7:0] LEVEL_0 = 8'd0;
	localparam logic [7:0] LEVEL_1 = 8'd85;
	localparam logic [7:0] LEVEL_2 = 8'd171;
	localparam logic [7:0] LEVEL_3 = 8'd255;

	// register indexes
	localparam logic [1:0] REG_KIND   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		KIND_CUBE  = 2'd0,
		KIND_GRAY  = 2'd1,
		KIND_COLOR = 2'd2,
		KIND_LUMA  = 2'd3
	} kind_t;

	typedef struct packed {
		logic issue;
		logic clear;
	} search_ctrl_t;

	typedef struct packed {
		logic busy;
		logic found;
	} search_stat_t;

	function automatic logic [7:0] cube_level(input logic [1:0] code);
		logic [7:0] lvl;
		unique case (code)
			2'd0: lvl = LEVEL_0;
			2'd1: lvl = LEVEL_1;
			2'd2: lvl = LEVEL_2;
			default: lvl = LEVEL_3;
		endcase
		return lvl;
	endfunction

endpackage

FILE: rtl/core/pdq_luma.sv
module pdq_luma (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       done,
	output logic [7:0] y
);

	logic [7:0]  r_q, g_q, b_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [23:0] acc_q;
	logic [15:0] coef;
	logic [7:0]  op;

	// one weight and one channel per cycle
	always_comb begin
		unique case (step_q)
			2'd0: begin coef = pdq_pkg::LUMA_KR; op = r_q; end
			2'd1: begin coef = pdq_pkg::LUMA_KG; op = g_q; end
			default: begin coef = pdq_pkg::LUMA_KB; op = b_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= busy_q && (step_q == 2'd2);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) busy_q <= 1'b0;
				step_q <= step_q + 2'd1;
			end
		end
	end

	// multiply-accumulate, full 24-bit product
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= red;
			g_q   <= green;
			b_q   <= blue;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + 24'(coef) * 24'(op);
		end
	end

	assign done = done_q;
	assign y    = acc_q[23:16];

endmodule

FILE: rtl/core/pdq_search.sv
module pdq_search #(
	parameter int PALETTE_SIZE = pdq_pkg::PALETTE_SIZE_DEF,
	parameter int CORR_W       = pdq_pkg::ERROR_BITS_DEF + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pdq_pkg::search_ctrl_t            ctrl,
	input  logic [$clog2(PALETTE_SIZE)-1:0]  idx,
	input  logic [31:0]                      pal_word,
	input  pdq_pkg::kind_t                   kind,
	input  logic signed [CORR_W-1:0]         corr_r,
	input  logic signed [CORR_W-1:0]         corr_g,
	input  logic signed [CORR_W-1:0]         corr_b,
	output pdq_pkg::search_stat_t            stat,
	output logic [$clog2(PALETTE_SIZE)-1:0]  best_idx,
	output logic [7:0]                       best_r,
	output logic [7:0]                       best_g,
	output logic [7:0]                       best_b
);

	localparam int IDX_W = $clog2(PALETTE_SIZE);
	localparam int DW    = CORR_W + 1;
	localparam int QW    = 2 * DW;
	localparam int SUMW  = QW + 2;

	// gray ramp table, built at elaboration
	logic [7:0] gray_lut [PALETTE_SIZE];
	for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_gray
		assign gray_lut[g] = 8'((g * 255) / (PALETTE_SIZE - 1));
	end

	logic             v_s1, v_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [7:0]       cand [3];
	logic [7:0]       cand_s2 [3];
	logic [QW-1:0]    sq_s2 [3];
	logic signed [CORR_W-1:0] corr [3];
	logic signed [DW-1:0]     diff [3];
	logic signed [QW-1:0]     prod [3];
	logic [5:0]       code;
	logic [SUMW-1:0]  cand_dist;
	logic             found_q;
	logic [SUMW-1:0]  best_d_q;
	logic [7:0]       best_q [3];
	logic [IDX_W-1:0] best_idx_q;

	assign corr[0] = corr_r;
	assign corr[1] = corr_g;
	assign corr[2] = corr_b;

	// candidate color for the entry in stage 1
	always_comb begin
		code = 6'd63 - 6'(idx_s1);
		unique case (kind)
			pdq_pkg::KIND_CUBE: begin
				cand[0] = pdq_pkg::cube_level(code[5:4]);
				cand[1] = pdq_pkg::cube_level(code[3:2]);
				cand[2] = pdq_pkg::cube_level(code[1:0]);
			end
			pdq_pkg::KIND_GRAY: begin
				cand[0] = gray_lut[idx_s1];
				cand[1] = gray_lut[idx_s1];
				cand[2] = gray_lut[idx_s1];
			end
			pdq_pkg::KIND_COLOR: begin
				cand[0] = pal_word[31:24];
				cand[1] = pal_word[23:16];
				cand[2] = pal_word[15:8];
			end
			default: begin
				cand[0] = pal_word[7:0];
				cand[1] = pal_word[7:0];
				cand[2] = pal_word[7:0];
			end
		endcase
		for (int c = 0; c < 3; c++) begin
			diff[c] = $signed({corr[c][CORR_W-1], corr[c]})
				- $signed({{(DW-8){1'b0}}, cand[c]});
			prod[c] = diff[c] * diff[c];
		end
	end

	assign cand_dist = SUMW'(sq_s2[0]) + SUMW'(sq_s2[1]) + SUMW'(sq_s2[2]);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			if (ctrl.clear) found_q <= 1'b0;
			else if (v_s2) found_q <= 1'b1;
		end
	end

	// squares, then sum and first-minimum compare
	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		idx_s2 <= idx_s1;
		for (int c = 0; c < 3; c++) begin
			sq_s2[c]   <= prod[c];
			cand_s2[c] <= cand[c];
		end
		if (v_s2 && !ctrl.clear && (!found_q || cand_dist < best_d_q)) begin
			best_d_q   <= cand_dist;
			best_idx_q <= idx_s2;
			for (int c = 0; c < 3; c++) best_q[c] <= cand_s2[c];
		end
	end

	assign stat.busy  = v_s1 | v_s2;
	assign stat.found = found_q;
	assign best_idx   = best_idx_q;
	assign best_r     = best_q[0];
	assign best_g     = best_q[1];
	assign best_b     = best_q[2];

endmodule

FILE: rtl/core/palette_dither_quantizer.sv
// Pixel flow: an accepted pixel passes the error read, the correction, the search
// and the diffusion before its result is offered; the imposed gray mode first runs
// the luma multiply-accumulate. The search unit scores one palette entry per cycle,
// and no new pixel or palette write is taken until the last one is through.
// Reset: asynchronous, active low; a clearing pass over all MAX_WIDTH + 2 entries of
// the error memory runs after reset and after each frame's last pixel.
module palette_dither_quantizer #(
	parameter int MAX_WIDTH    = pdq_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_SIZE = pdq_pkg::PALETTE_SIZE_DEF,
	parameter int ERROR_BITS   = pdq_pkg::ERROR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [5:0]  entry,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  color_index,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_end
);

	localparam int IDX_W = $clog2(PALETTE_SIZE);
	localparam int CNT_W = $clog2(MAX_WIDTH);
	localparam int DEPTH = MAX_WIDTH + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int EB    = ERROR_BITS;
	localparam int CW    = EB + 1;
	localparam int SW    = CW + 4;
	localparam int LIM   = (1 << (EB - 1)) - 1;
	localparam logic signed [SW-1:0] LIM_POS = SW'(LIM);
	localparam logic signed [SW-1:0] LIM_NEG = -SW'(LIM);
	localparam logic signed [SW-1:0] K15 = SW'(15);
	localparam logic signed [SW-1:0] K0  = SW'(0);
	localparam logic signed [SW-1:0] K7  = SW'(7);
	localparam logic signed [SW-1:0] K5  = SW'(5);
	localparam logic signed [SW-1:0] K3  = SW'(3);

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_LUMA   = 10'b0000000100,
		S_RDERR  = 10'b0000001000,
		S_CORR   = 10'b0000010000,
		S_SEARCH = 10'b0000100000,
		S_DRAIN  = 10'b0001000000,
		S_DIFF   = 10'b0010000000,
		S_WRX    = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	function automatic logic signed [EB-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		if (v > LIM_POS) t = LIM_POS;
		else if (v < LIM_NEG) t = LIM_NEG;
		else t = v;
		return t[EB-1:0];
	endfunction

	function automatic logic signed [SW-1:0] sx(input logic signed [EB-1:0] v);
		return $signed({{(SW-EB){v[EB-1]}}, v});
	endfunction

	// divide by 16, truncating toward zero
	function automatic logic signed [SW-1:0] d16(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		t = v + (v[SW-1] ? K15 : K0);
		return t >>> 4;
	endfunction

	state_t         state_q;
	pdq_pkg::kind_t kind_q;
	logic [10:0]    width_q, height_q;

	logic [7:0]       pix_q [3];
	logic             mode_q;
	logic [5:0]       entry_q;
	logic [AW-1:0]    clr_addr_q;
	logic [CNT_W-1:0] col_q;
	logic [9:0]       row_q;
	logic [IDX_W-1:0] i_q;
	logic signed [EB-1:0] right_q [3];
	logic signed [EB-1:0] carry_q [3];
	logic signed [EB-1:0] held_q  [3];
	logic signed [EB-1:0] wrx_q   [3];
	logic [AW-1:0]    wrx_addr_q;
	logic             wrx_en_q;
	logic             last_frame_q;
	logic signed [CW-1:0] corr_q [3];

	logic        out_valid_q;
	logic [5:0]  color_index_q;
	logic [7:0]  out_rgb_q [3];
	logic        frame_end_q;

	logic        cfg_wr;
	logic        accept;
	logic        luma_done;
	logic [7:0]  luma_y;
	logic        out_load;

	logic [3*EB-1:0] err_mem [DEPTH];
	logic [3*EB-1:0] err_rd_q;
	logic            err_we;
	logic [AW-1:0]   err_wa;
	logic [3*EB-1:0] err_wd;
	logic [AW-1:0]   err_ra;

	logic [31:0] pal_mem [PALETTE_SIZE];
	logic [31:0] pal_rd_q;
	logic        pal_we;

	pdq_pkg::search_ctrl_t srch_ctrl;
	pdq_pkg::search_stat_t srch_stat;
	logic [IDX_W-1:0]      best_idx;
	logic [7:0]            best_rgb [3];

	logic signed [EB-1:0] corr_sat [3];
	logic signed [SW-1:0] corr_sum [3];
	logic signed [SW-1:0] e_w [3];
	logic signed [SW-1:0] s7_w [3], s5_w [3], s3_w [3], s1_w [3];
	logic signed [EB-1:0] nx1_w [3], nx0_w [3];
	logic [10:0] w_eff, h_eff;
	logic        last_col, last_row, last_frame_w;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= pdq_pkg::KIND_CUBE;
			width_q  <= 11'd640;
			height_q <= 11'd480;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pdq_pkg::REG_KIND:   kind_q   <= pdq_pkg::kind_t'(pwdata[1:0]);
				pdq_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
				pdq_pkg::REG_HEIGHT: height_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pdq_pkg::REG_KIND:   prdata = {30'd0, kind_q};
			pdq_pkg::REG_WIDTH:  prdata = {21'd0, width_q};
			pdq_pkg::REG_HEIGHT: prdata = {21'd0, height_q};
			default:             prdata = 32'd0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// luma unit
	pdq_luma u_luma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (mode || kind_q == pdq_pkg::KIND_GRAY)),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.done   (luma_done),
		.y      (luma_y)
	);

	// loaded palette
	assign pal_we = (state_q == S_LUMA) && luma_done && mode_q
		&& (int'(entry_q) < PALETTE_SIZE);

	always_ff @(posedge clk) begin
		if (pal_we) pal_mem[IDX_W'(entry_q)] <= {pix_q[0], pix_q[1], pix_q[2], luma_y};
		pal_rd_q <= pal_mem[i_q];
	end

	// nearest-color search
	assign srch_ctrl.issue = (state_q == S_SEARCH);
	assign srch_ctrl.clear = (state_q == S_CORR);

	pdq_search #(
		.PALETTE_SIZE (PALETTE_SIZE),
		.CORR_W       (CW)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (srch_ctrl),
		.idx      (i_q),
		.pal_word (pal_rd_q),
		.kind     (kind_q),
		.corr_r   (corr_q[0]),
		.corr_g   (corr_q[1]),
		.corr_b   (corr_q[2]),
		.stat     (srch_stat),
		.best_idx (best_idx),
		.best_r   (best_rgb[0]),
		.best_g   (best_rgb[1]),
		.best_b   (best_rgb[2])
	);

	// correction and diffusion arithmetic, per channel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			corr_sat[c] = sat(sx(err_rd_q[c*EB +: EB]) + sx(right_q[c]));
			corr_sum[c] = $signed({{(SW-8){1'b0}}, pix_q[c]}) + sx(corr_sat[c]);
			e_w[c] = $signed({{(SW-CW){corr_q[c][CW-1]}}, corr_q[c]})
				- $signed({{(SW-8){1'b0}}, best_rgb[c]});
			s7_w[c]  = d16(e_w[c] * K7);
			s5_w[c]  = d16(e_w[c] * K5);
			s3_w[c]  = d16(e_w[c] * K3);
			s1_w[c]  = d16(e_w[c]);
			nx1_w[c] = sat(sx(carry_q[c]) + s5_w[c]);
			nx0_w[c] = sat(sx(held_q[c]) + s3_w[c]);
		end
	end

	// row and frame end
	assign w_eff = (width_q == 11'd0) ? 11'd1 : width_q;
	assign h_eff = (height_q == 11'd0) ? 11'd1 : height_q;
	assign last_col = (32'(col_q) + 32'd1 >= 32'(w_eff))
		|| (32'(col_q) + 32'd1 >= 32'(MAX_WIDTH));
	assign last_row = (32'(row_q) + 32'd1 >= 32'(h_eff))
		|| (32'(row_q) + 32'd1 >= 32'(pdq_pkg::MAX_HEIGHT));
	assign last_frame_w = last_col && last_row;

	// error memory port selection
	assign err_ra = AW'(col_q) + AW'(1);

	always_comb begin
		err_we = 1'b0;
		err_wa = clr_addr_q;
		err_wd = '0;
		priority if (state_q == S_CLEAR) begin
			err_we = 1'b1;
		end else if (state_q == S_DIFF) begin
			err_we = 1'b1;
			err_wa = AW'(col_q) + AW'(1);
			for (int c = 0; c < 3; c++) err_wd[c*EB +: EB] = nx1_w[c];
		end else if (state_q == S_WRX) begin
			err_we = wrx_en_q;
			err_wa = wrx_addr_q;
			for (int c = 0; c < 3; c++) err_wd[c*EB +: EB] = wrx_q[c];
		end else begin
			err_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (err_we) err_mem[err_wa] <= err_wd;
		err_rd_q <= err_mem[err_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			col_q        <= '0;
			row_q        <= '0;
			i_q          <= '0;
			out_valid_q  <= 1'b0;
			last_frame_q <= 1'b0;
			wrx_en_q     <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				right_q[c] <= '0;
				carry_q[c] <= '0;
				held_q[c]  <= '0;
			end
		end else begin
			// output valid: set on load, dropped once the transaction is taken
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (clr_addr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
					else clr_addr_q <= clr_addr_q + AW'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						if (mode || kind_q == pdq_pkg::KIND_GRAY) state_q <= S_LUMA;
						else state_q <= S_RDERR;
					end
				end
				S_LUMA: begin
					if (luma_done) state_q <= mode_q ? S_IDLE : S_RDERR;
				end
				S_RDERR: state_q <= S_CORR;
				S_CORR: begin
					i_q     <= '0;
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					i_q <= i_q + IDX_W'(1);
					if (i_q == IDX_W'(PALETTE_SIZE - 1)) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!srch_stat.busy) state_q <= S_DIFF;
				end
				S_DIFF: begin
					last_frame_q <= last_frame_w;
					wrx_en_q     <= (col_q != '0);
					for (int c = 0; c < 3; c++) begin
						held_q[c]  <= nx1_w[c];
						carry_q[c] <= last_col ? '0 : sat(s1_w[c]);
						right_q[c] <= last_col ? '0 : sat(s7_w[c]);
					end
					if (last_frame_w) begin
						col_q <= '0;
						row_q <= '0;
					end else if (last_col) begin
						col_q <= '0;
						row_q <= row_q + 10'd1;
					end else begin
						col_q <= col_q + CNT_W'(1);
					end
					state_q <= S_WRX;
				end
				S_WRX: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						clr_addr_q <= '0;
						state_q    <= last_frame_q ? S_CLEAR : S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			entry_q  <= entry;
			pix_q[0] <= red;
			pix_q[1] <= green;
			pix_q[2] <= blue;
		end else if (state_q == S_LUMA && luma_done && !mode_q) begin
			for (int c = 0; c < 3; c++) pix_q[c] <= luma_y;
		end
		if (state_q == S_CORR) begin
			for (int c = 0; c < 3; c++) corr_q[c] <= corr_sum[c][CW-1:0];
		end
		if (state_q == S_DIFF) begin
			wrx_addr_q <= AW'(col_q);
			for (int c = 0; c < 3; c++) wrx_q[c] <= nx0_w[c];
		end
		if (out_load) begin
			color_index_q <= 6'(best_idx);
			frame_end_q   <= last_frame_q;
			for (int c = 0; c < 3; c++) out_rgb_q[c] <= best_rgb[c];
		end
	end

	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;
	assign out_red     = out_rgb_q[0];
	assign out_green   = out_rgb_q[1];
	assign out_blue    = out_rgb_q[2];
	assign frame_end   = frame_end_q;

`ifndef SYNTHESIS
	a_found_before_diffuse: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIFF) |-> srch_stat.found)
		else $error("diffusion without a search result");

	a_luma_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		luma_done |-> (state_q == S_LUMA))
		else $error("luma result outside luma wait");

	a_no_err_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !err_we)
		else $error("error memory written while idle");

	a_search_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && i_q == IDX_W'(PALETTE_SIZE - 1)) |=>
		(state_q == S_DRAIN && srch_stat.busy))
		else $error("search pipeline empty after last entry");
`endif

endmodule

FILE: tb/tb_palette_dither_quantizer.sv
`timescale 1ns / 100ps

module tb_palette_dither_quantizer;

	localparam int ERR_MAX     = 2047;
	localparam int MAX_W       = 1024;
	localparam int RAND_ITEMS  = 1850;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 1200;  // covers search latency and the clearing pass

	typedef struct {
		logic [5:0] color_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_end;
	} color_result_t;

	typedef struct {
		logic       mode;
		logic [5:0] entry;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         typed;
		logic [5:0] t_index;
		logic [7:0] t_red;
		logic [7:0] t_green;
		logic [7:0] t_blue;
		logic       t_end;
	} stim_row_t;

	typedef struct {
		pdq_pkg::kind_t kind;
		logic [10:0]    width;
		logic [10:0]    height;
	} frame_cfg_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [5:0]  entry = '0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  color_index;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        frame_end;

	palette_dither_quantizer dut (.*);

	// shadow of the block's state
	pdq_pkg::kind_t cur_kind;
	int         cur_width;
	int         cur_height;
	logic [7:0] pal_mem [64][3];
	int         below_err [MAX_W + 2][3];
	int         right_err [3];
	int         diag_carry [3];
	int         col_cnt;
	int         row_cnt;

	color_result_t pending_colors [$];
	int            err_count = 0;
	int            cycle_count = 0;
	bit            calm = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		err_count++;
	endtask

	function automatic int sat_err(input int v);
		if (v > ERR_MAX) return ERR_MAX;
		if (v < -ERR_MAX) return -ERR_MAX;
		return v;
	endfunction

	function automatic int luma_of(input int r, input int g, input int b);
		int unsigned s;
		s = 19595 * r + 38470 * g + 7471 * b;
		return int'(s >> 16);
	endfunction

	function automatic int level_of(input int code);
		int lv;
		case (code)
			0: lv = 0;
			1: lv = 85;
			2: lv = 171;
			default: lv = 255;
		endcase
		return lv;
	endfunction

	function automatic void pal_color(input int i, output int rgb[3]);
		int c;
		int y;
		case (cur_kind)
			pdq_pkg::KIND_CUBE: begin
				c = 63 - i;
				rgb[0] = level_of((c >> 4) & 3);
				rgb[1] = level_of((c >> 2) & 3);
				rgb[2] = level_of(c & 3);
			end
			pdq_pkg::KIND_GRAY: begin
				y = (i * 255) / 63;
				rgb = '{y, y, y};
			end
			pdq_pkg::KIND_COLOR: begin
				rgb = '{int'(pal_mem[i][0]), int'(pal_mem[i][1]), int'(pal_mem[i][2])};
			end
			default: begin
				y = luma_of(int'(pal_mem[i][0]), int'(pal_mem[i][1]), int'(pal_mem[i][2]));
				rgb = '{y, y, y};
			end
		endcase
	endfunction

	function automatic void clear_frame_state();
		foreach (below_err[k, c]) below_err[k][c] = 0;
		right_err = '{0, 0, 0};
		diag_carry = '{0, 0, 0};
		col_cnt = 0;
		row_cnt = 0;
	endfunction

	// error-diffused nearest-color pick for one pixel
	function automatic color_result_t dither_pixel(input int r, input int g, input int b);
		color_result_t res;
		int w, h, x, y, best, bestd, d, diff, e;
		int pix[3];
		int corr[3];
		int cand[3];
		int best_rgb[3];
		bit last_col, last_frame;
		w = cur_width < 1 ? 1 : (cur_width > MAX_W ? MAX_W : cur_width);
		h = cur_height < 1 ? 1 : (cur_height > 1024 ? 1024 : cur_height);
		x = col_cnt > MAX_W - 1 ? MAX_W - 1 : col_cnt;
		pix = '{r, g, b};
		if (cur_kind == pdq_pkg::KIND_GRAY) begin
			y = luma_of(r, g, b);
			pix = '{y, y, y};
		end
		for (int c = 0; c < 3; c++)
			corr[c] = pix[c] + sat_err(below_err[x + 1][c] + right_err[c]);
		best = 0;
		bestd = -1;
		best_rgb = '{0, 0, 0};
		for (int i = 0; i < 64; i++) begin
			pal_color(i, cand);
			d = 0;
			for (int c = 0; c < 3; c++) begin
				diff = corr[c] - cand[c];
				d += diff * diff;
			end
			if (bestd < 0 || d < bestd) begin
				bestd = d;
				best = i;
				best_rgb = cand;
			end
		end
		last_col = (x + 1 >= w);
		for (int c = 0; c < 3; c++) begin
			e = corr[c] - best_rgb[c];
			if (x > 0)
				below_err[x][c] = sat_err(below_err[x][c] + (e * 3) / 16);
			below_err[x + 1][c] = sat_err(diag_carry[c] + (e * 5) / 16);
			diag_carry[c] = last_col ? 0 : sat_err(e / 16);
			right_err[c] = last_col ? 0 : sat_err((e * 7) / 16);
		end
		last_frame = last_col && (row_cnt + 1 >= h);
		if (last_frame) begin
			clear_frame_state();
		end else if (last_col) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1) & 32'h3FF;
		end else begin
			col_cnt = x + 1;
		end
		res.color_index = best[5:0];
		res.out_red = best_rgb[0][7:0];
		res.out_green = best_rgb[1][7:0];
		res.out_blue = best_rgb[2][7:0];
		res.frame_end = last_frame;
		return res;
	endfunction

	// register write, setup then access
	task automatic reg_write(input logic [1:0] idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_cfg(input frame_cfg_t cfg);
		reg_write(pdq_pkg::REG_KIND, int'(cfg.kind));
		cur_kind = cfg.kind;
		reg_write(pdq_pkg::REG_WIDTH, int'(cfg.width));
		cur_width = int'(cfg.width);
		reg_write(pdq_pkg::REG_HEIGHT, int'(cfg.height));
		cur_height = int'(cfg.height);
	endtask

	// wait for all results, then let the block settle
	task automatic drain();
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one input transaction; predictor runs at acceptance
	task automatic send_item(input stim_row_t row);
		color_result_t res;
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= row.mode;
		entry <= row.entry;
		red <= row.red;
		green <= row.green;
		blue <= row.blue;
		do @(posedge clk); while (in_stall);
		if (row.mode) begin
			pal_mem[row.entry] = '{row.red, row.green, row.blue};
		end else begin
			res = dither_pixel(int'(row.red), int'(row.green), int'(row.blue));
			if (row.typed) begin
				res.color_index = row.t_index;
				res.out_red = row.t_red;
				res.out_green = row.t_green;
				res.out_blue = row.t_blue;
				res.frame_end = row.t_end;
			end
			pending_colors.push_back(res);
		end
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_chan(input bit extreme);
		if (extreme) return $urandom_range(1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(255));
	endfunction

	function automatic stim_row_t rand_item(input bit pixel_only);
		stim_row_t row;
		bit ext;
		row = '{default: '0};
		row.mode = pixel_only ? 1'b0 : ($urandom_range(99) < 10);
		row.entry = 6'($urandom_range(63));
		ext = ($urandom_range(99) < 20);
		row.red = rand_chan(ext);
		row.green = rand_chan(ext);
		row.blue = rand_chan(ext);
		return row;
	endfunction

	// result check and output stall
	always @(posedge clk) begin
		color_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_colors.size() == 0) begin
				report_mismatch("unexpected result, color_index", int'(color_index), -1);
			end else begin
				want = pending_colors.pop_front();
				if (color_index !== want.color_index)
					report_mismatch("color_index", int'(color_index),
						int'(want.color_index));
				if (out_red !== want.out_red)
					report_mismatch("out_red", int'(out_red), int'(want.out_red));
				if (out_green !== want.out_green)
					report_mismatch("out_green", int'(out_green), int'(want.out_green));
				if (out_blue !== want.out_blue)
					report_mismatch("out_blue", int'(out_blue), int'(want.out_blue));
				if (frame_end !== want.frame_end)
					report_mismatch("frame_end", int'(frame_end), int'(want.frame_end));
			end
		end
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 12);
	end

	stim_row_t directed_rows [] = '{
		// reset config: cube palette, 640 x 480, no error yet
		'{1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b1, 6'd63, 8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b0, 6'd63, 8'd255, 8'd255, 8'd255, 1'b1, 6'd0,  8'd255, 8'd255, 8'd255, 1'b0},
		'{1'b0, 6'd0,  8'd255, 8'd255, 8'd255, 1'b1, 6'd0,  8'd255, 8'd255, 8'd255, 1'b0},
		'{1'b0, 6'd5,  8'd0,   8'd0,   8'd255, 1'b1, 6'd60, 8'd0,   8'd0,   8'd255, 1'b0},
		'{1'b0, 6'd0,  8'd128, 8'd128, 8'd128, 1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b0, 6'd0,  8'd42,  8'd43,  8'd127, 1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b0, 6'd0,  8'd255, 8'd0,   8'd255, 1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b0, 6'd0,  8'd1,   8'd254, 8'd1,   1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		// palette writes, lowest and highest slot
		'{1'b1, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b1, 6'd63, 8'd255, 8'd255, 8'd255, 1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b0, 6'd0,  8'd170, 8'd86,  8'd0,   1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0},
		'{1'b0, 6'd0,  8'd255, 8'd255, 8'd255, 1'b0, 6'd0,  8'd0,   8'd0,   8'd0,   1'b0}
	};

	// settings walked by the random part; extremes and out-of-range sizes included
	frame_cfg_t phase_cfgs [] = '{
		'{pdq_pkg::KIND_CUBE,  11'd5,    11'd3},
		'{pdq_pkg::KIND_GRAY,  11'd7,    11'd4},
		'{pdq_pkg::KIND_COLOR, 11'd1,    11'd1},
		'{pdq_pkg::KIND_LUMA,  11'd6,    11'd5},
		'{pdq_pkg::KIND_CUBE,  11'd0,    11'd0},
		'{pdq_pkg::KIND_COLOR, 11'd1024, 11'd1024},
		'{pdq_pkg::KIND_GRAY,  11'd2047, 11'd2},
		'{pdq_pkg::KIND_LUMA,  11'd2,    11'd2047},
		'{pdq_pkg::KIND_COLOR, 11'd16,   11'd3},
		'{pdq_pkg::KIND_CUBE,  11'd3,    11'd1},
		'{pdq_pkg::KIND_LUMA,  11'd1024, 11'd1},
		'{pdq_pkg::KIND_GRAY,  11'd9,    11'd6},
		'{pdq_pkg::KIND_COLOR, 11'd4,    11'd8},
		'{pdq_pkg::KIND_CUBE,  11'd640,  11'd480}
	};

	initial begin
		stim_row_t row;
		int per_phase;
		cur_kind = pdq_pkg::KIND_CUBE;
		cur_width = 640;
		cur_height = 480;
		foreach (pal_mem[k, c]) pal_mem[k][c] = '0;
		clear_frame_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings
		foreach (directed_rows[k]) send_item(directed_rows[k]);
		idle_input();
		drain();

		// fill the whole loaded palette before it is ever read
		for (int k = 0; k < 64; k++) begin
			row = rand_item(1'b1);
			row.mode = 1'b1;
			row.entry = 6'(k);
			send_item(row);
		end
		idle_input();
		drain();

		// random phases
		per_phase = RAND_ITEMS / phase_cfgs.size();
		foreach (phase_cfgs[p]) begin
			apply_cfg(phase_cfgs[p]);
			calm = (p == 3);
			for (int k = 0; k < per_phase; k++) begin
				send_item(rand_item(1'b0));
				// sender holds off once until every result is back
				if (p == 8 && k == per_phase / 2) begin
					idle_input();
					while (pending_colors.size() != 0) @(posedge clk);
				end
			end
			calm = 1'b0;
			idle_input();
			drain();
		end

		repeat (200) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
